// File: sv/bcpe_pkg.sv
// Package for the Bezier curve point evaluator.
// Holds the request and result payload types and the fixed-point constants.
// No dependencies.
`default_nettype none

package bcpe_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CountW       = 7;
  localparam int unsigned TW           = 17;
  localparam int unsigned HW           = 25;
  localparam int unsigned FracH        = 24;
  localparam int unsigned CoordW       = 32;
  localparam int unsigned CountReset   = 4;

  localparam logic [TW-1:0] TOne = TW'(65536);
  localparam logic [HW-1:0] HOne = HW'(1) << FracH;

  typedef struct packed {
    logic        [TW-1:0]     param_t;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } bcpe_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] curve_x;
    logic signed [CoordW-1:0] curve_y;
    logic signed [CoordW-1:0] curve_z;
  } bcpe_out_t;

endpackage

`default_nettype wire

// File: sv/bezier_curve_point_eval_core.sv
// Bezier curve point evaluator, top level.
// Depends on bcpe_pkg for payload types and fixed-point constants.
//
// Control points stream in one request at a time; after point_count points the
// evaluated curve point is delivered. The first point of a curve goes from idle
// straight to the final state. Every later point runs through one bit-serial
// datapath: a shift-add multiply over the 17 bits of t, a shift-add multiply over
// the clog2(MAX_POINTS+1) bits of n-k, a restoring divider producing 25 quotient
// bits, and a shift-add blend over the 25 bits of h for x, y and z in parallel;
// a zero denominator skips the divider and blend. One point is in work at a
// time; a finished curve point waits in the output register while the next
// request is taken.
`default_nettype none

module bezier_curve_point_eval_core #(
  parameter int unsigned MAX_POINTS = bcpe_pkg::MaxPointsDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire bcpe_pkg::bcpe_in_t        in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output bcpe_pkg::bcpe_out_t            out_data_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [bcpe_pkg::CountW-1:0] cfg_data_i
);
  import bcpe_pkg::*;

  localparam int unsigned NW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned CmpW  = (NW > CountW) ? NW : CountW;
  localparam int unsigned ProdW = HW + TW;
  localparam int unsigned NumW  = ProdW + NW;
  localparam int unsigned KtW   = TW + NW;
  localparam int unsigned DenW  = NumW + 1;
  localparam int unsigned RemW  = DenW + 1;
  localparam int unsigned AccW  = CoordW + FracH + 2;
  localparam int unsigned StW   = 3;
  localparam int unsigned CycW  = 5;

  localparam logic [StW-1:0] S_IDLE  = 3'd0;
  localparam logic [StW-1:0] S_MUL1  = 3'd1;
  localparam logic [StW-1:0] S_MUL2  = 3'd2;
  localparam logic [StW-1:0] S_DIV   = 3'd3;
  localparam logic [StW-1:0] S_BLEND = 3'd4;
  localparam logic [StW-1:0] S_FIN   = 3'd5;

  localparam logic [CycW-1:0] LastMul1 = CycW'(TW - 1);
  localparam logic [CycW-1:0] LastMul2 = CycW'(NW - 1);
  localparam logic [CycW-1:0] LastDiv  = CycW'(HW - 1);
  localparam logic [AccW-1:0] RoundHalf = AccW'(1) << (FracH - 1);

  logic [StW-1:0]  state_q, state_d;
  logic [CycW-1:0] cyc_q, cyc_d;
  logic [CountW-1:0] count_q;
  logic [NW-1:0]   idx_q, idx_d;
  logic [NW-1:0]   k_q, k_d;
  logic [HW-1:0]   h_q, h_d;
  logic [NumW-1:0] mcand_q, mcand_d;
  logic [TW-1:0]   mplier_q, mplier_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [KtW-1:0]  ktc_q, ktc_d;
  logic [NW-1:0]   ktm_q, ktm_d;
  logic [KtW-1:0]  kt_q, kt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [HW-1:0]   quo_q, quo_d;
  logic [HW-1:0]   hm_q, hm_d;

  logic signed [CoordW-1:0] acc_q [3];
  logic signed [CoordW-1:0] acc_d [3];
  logic signed [CoordW-1:0] pt_q  [3];
  logic signed [CoordW-1:0] pt_d  [3];
  logic signed [AccW-1:0]   bacc_q [3];
  logic signed [AccW-1:0]   bacc_d [3];
  logic signed [AccW-1:0]   bmc_q [3];
  logic signed [AccW-1:0]   bmc_d [3];

  logic      out_valid_q, out_valid_d;
  bcpe_out_t out_q, out_d;

  logic [CmpW-1:0] cnt_ext;
  logic [NW-1:0]   n_eff;
  logic [TW-1:0]   t_sat;
  logic            in_acc;
  logic [NW-1:0]   k_in;
  logic [NW-1:0]   idx_nx;
  logic            run_done;
  logic            out_free;
  logic [DenW-1:0] den_calc;
  logic [RemW-1:0] rem_sh;
  logic            rem_ge;
  logic signed [CoordW:0] diff [3];

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !(out_valid_q && out_stall_i);

  always_comb begin
    cnt_ext = CmpW'(count_q);
    if (cnt_ext == '0) begin
      n_eff = NW'(1);
    end else if (cnt_ext > CmpW'(MAX_POINTS)) begin
      n_eff = NW'(MAX_POINTS);
    end else begin
      n_eff = NW'(cnt_ext);
    end
  end

  assign t_sat    = (in_data_i.param_t > TOne) ? TOne : in_data_i.param_t;
  assign k_in     = (idx_q >= n_eff) ? '0 : idx_q;
  assign idx_nx   = k_q + NW'(1);
  assign run_done = (idx_nx >= n_eff);
  assign den_calc = (DenW'(kt_q) << FracH) + DenW'(num_q);
  assign rem_sh   = (cyc_q == '0) ? rem_q : (rem_q << 1);
  assign rem_ge   = (rem_sh >= RemW'(den_q));

  for (genvar l = 0; l < 3; l++) begin : g_diff
    assign diff[l] = {pt_q[l][CoordW-1], pt_q[l]} - {acc_q[l][CoordW-1], acc_q[l]};
  end

  always_comb begin
    state_d  = state_q;
    cyc_d    = cyc_q;
    idx_d    = idx_q;
    k_d      = k_q;
    h_d      = h_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    prod_d   = prod_q;
    ktc_d    = ktc_q;
    ktm_d    = ktm_q;
    kt_d     = kt_q;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    hm_d     = hm_q;
    acc_d    = acc_q;
    pt_d     = pt_q;
    bacc_d   = bacc_q;
    bmc_d    = bmc_q;
    out_d    = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          k_d      = k_in;
          pt_d[0]  = in_data_i.point_x;
          pt_d[1]  = in_data_i.point_y;
          pt_d[2]  = in_data_i.point_z;
          mcand_d  = NumW'(h_q);
          mplier_d = t_sat;
          prod_d   = '0;
          ktc_d    = KtW'(TOne - t_sat);
          ktm_d    = k_in;
          kt_d     = '0;
          cyc_d    = '0;
          if (k_in == '0) begin
            h_d     = HOne;
            acc_d[0] = in_data_i.point_x;
            acc_d[1] = in_data_i.point_y;
            acc_d[2] = in_data_i.point_z;
            state_d = S_FIN;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        if (mplier_q[0]) begin
          prod_d = prod_q + ProdW'(mcand_q);
        end
        if (ktm_q[0]) begin
          kt_d = kt_q + ktc_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        ktc_d    = ktc_q << 1;
        ktm_d    = ktm_q >> 1;
        cyc_d    = cyc_q + CycW'(1);
        if (cyc_q == LastMul1) begin
          mcand_d  = NumW'(prod_d);
          mplier_d = TW'(n_eff - k_q);
          num_d    = '0;
          cyc_d    = '0;
          state_d  = S_MUL2;
        end
      end
      S_MUL2: begin
        if (mplier_q[0]) begin
          num_d = num_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cyc_d    = cyc_q + CycW'(1);
        if (cyc_q == LastMul2) begin
          state_d = S_DIV;
          cyc_d   = '0;
        end
      end
      S_DIV: begin
        if (rem_ge) begin
          rem_d = rem_sh - RemW'(den_q);
        end else begin
          rem_d = rem_sh;
        end
        quo_d = {quo_q[HW-2:0], rem_ge};
        cyc_d = cyc_q + CycW'(1);
        if (cyc_q == LastDiv) begin
          h_d   = quo_d;
          hm_d  = quo_d;
          cyc_d = '0;
          for (int l = 0; l < 3; l++) begin
            bacc_d[l] = $signed({{2{acc_q[l][CoordW-1]}}, acc_q[l], {FracH{1'b0}}}) +
                        $signed(RoundHalf);
            bmc_d[l]  = AccW'(diff[l]);
          end
          state_d = S_BLEND;
        end
      end
      S_BLEND: begin
        for (int l = 0; l < 3; l++) begin
          if (hm_q[0]) begin
            bacc_d[l] = bacc_q[l] + bmc_q[l];
          end
          bmc_d[l] = bmc_q[l] <<< 1;
        end
        hm_d  = hm_q >> 1;
        cyc_d = cyc_q + CycW'(1);
        if (cyc_q == LastDiv) begin
          for (int l = 0; l < 3; l++) begin
            acc_d[l] = bacc_d[l][CoordW+FracH-1:FracH];
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!run_done) begin
          idx_d   = idx_nx;
          state_d = S_IDLE;
        end else if (out_free) begin
          out_d.curve_x = acc_q[0];
          out_d.curve_y = acc_q[1];
          out_d.curve_z = acc_q[2];
          out_valid_d   = 1'b1;
          idx_d   = '0;
          h_d     = HOne;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (state_q == S_MUL2 && cyc_q == LastMul2) begin
      den_d = den_calc;
      rem_d = RemW'(num_d);
      quo_d = '0;
      if ((DenW'(kt_q) << FracH) + DenW'(num_d) == '0) begin
        h_d     = '0;
        state_d = S_FIN;
      end
      den_d = (DenW'(kt_q) << FracH) + DenW'(num_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cyc_q       <= '0;
      idx_q       <= '0;
      h_q         <= HOne;
      count_q     <= CountW'(CountReset);
      out_valid_q <= 1'b0;
      acc_q[0]    <= '0;
      acc_q[1]    <= '0;
      acc_q[2]    <= '0;
    end else begin
      state_q     <= state_d;
      cyc_q       <= cyc_d;
      idx_q       <= idx_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    prod_q   <= prod_d;
    ktc_q    <= ktc_d;
    ktm_q    <= ktm_d;
    kt_q     <= kt_d;
    num_q    <= num_d;
    den_q    <= den_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    hm_q     <= hm_d;
    pt_q     <= pt_d;
    bacc_q   <= bacc_d;
    bmc_q    <= bmc_d;
    out_q    <= out_d;
  end

endmodule

`default_nettype wire
